/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// boolean that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication checked in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hdl/tmt_pkg.sv */
`default_nettype none
package tmt_pkg;

    localparam int TIME_W       = 48;
    localparam int PERIOD_W     = 32;
    localparam int EXP_W        = 16;
    localparam int MPT_W        = 10;
    localparam int PROD_W       = EXP_W + MPT_W;
    localparam int REQ_W        = 2;
    localparam int KIND_W       = 3;
    localparam int SLOT_FIELD_W = 4;
    localparam int IN_DATA_W    = 56;
    localparam int OUT_DATA_W   = 8;

    localparam logic [MPT_W-1:0]  MPT_RESET = MPT_W'(10);
    localparam logic [TIME_W-1:0] TIME_MAX  = '1;

    typedef logic [REQ_W-1:0]  req_t;
    typedef logic [KIND_W-1:0] kind_t;

    localparam req_t REQ_TICK   = 2'd0;
    localparam req_t REQ_ADD    = 2'd1;
    localparam req_t REQ_CANCEL = 2'd2;

    localparam kind_t KIND_ADDED     = 3'd0;
    localparam kind_t KIND_FULL      = 3'd1;
    localparam kind_t KIND_FIRED     = 3'd2;
    localparam kind_t KIND_TICK_DONE = 3'd3;
    localparam kind_t KIND_CANCELLED = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK_ADD,
        ST_SCAN,
        ST_TICK_DONE,
        ST_ADD_FIND,
        ST_ADD_WR,
        ST_CANCEL
    } state_t;

endpackage
`default_nettype wire

/* hdl/periodic_and_oneshot_timer_table_core.sv */
`default_nettype none
`include "assert_macros.svh"
// Table of NUM_SLOTS tick-driven software timers. One item is taken at a time; s_axis_tready
// is high only while the sequencer is idle. An add walks the live bits one slot per cycle to
// find the lowest free slot. A tick first forms the expirations * ms_per_tick product as the
// item is taken, then updates the time, then scans the slot memory (one read per cycle while
// the output register is free), then sends the done item. Every fired slot and every closing
// item waits for the output register to be free, so a stalled master side holds the sequencer.
// Time and deadlines saturate at 2^48 - 1.
module periodic_and_oneshot_timer_table_core #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tmt_pkg::MPT_W-1:0]      cfg_wdata,      // ms_per_tick
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // expirations[15:0], delay_ms[47:16], one_shot[48], slot_id[52:49], zero[55:53]
    input  logic [tmt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [tmt_pkg::REQ_W-1:0]      s_axis_tuser,   // req_type[1:0]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // kind[2:0], slot[6:3], zero[7]
    output logic [tmt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast    // last
);

    import tmt_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
    localparam int ENTRY_W = 1 + PERIOD_W + TIME_W;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    state_t               state_reg, state_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [MPT_W-1:0]     mpt_reg, mpt_next;
    logic [NUM_SLOTS-1:0] live_reg, live_next;
    logic                 out_valid_reg, out_valid_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [PERIOD_W-1:0]  delay_reg, delay_next;
    logic                 once_reg, once_next;
    logic [SLOT_FIELD_W-1:0] sid_reg, sid_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    kind_t                out_kind_reg, out_kind_next;
    logic [SLOT_FIELD_W-1:0] out_slot_reg, out_slot_next;
    logic                 out_last_reg, out_last_next;

    logic [IDX_W-1:0]     rd_addr;
    logic                 ram_we;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   rd_data;
    logic [TIME_W-1:0]    rd_deadline;
    logic [PERIOD_W-1:0]  rd_period;
    logic                 rd_once;
    logic [TIME_W-1:0]    add_b;
    logic [TIME_W-1:0]    sum_sat;
    logic                 fire;
    logic                 out_free;
    logic                 in_accept;
    logic                 emit;
    kind_t                emit_kind;
    logic [SLOT_FIELD_W-1:0] emit_slot;
    logic                 emit_last;

    tmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_deadline = rd_data[TIME_W-1:0];
    assign rd_period   = rd_data[TIME_W +: PERIOD_W];
    assign rd_once     = rd_data[ENTRY_W-1];

    // shared saturating time adder
    always_comb
    begin
        case (state_reg)
            ST_TICK_ADD: add_b = TIME_W'(prod_reg);
            ST_ADD_WR:   add_b = TIME_W'(delay_reg);
            default:     add_b = TIME_W'(rd_period);
        endcase
    end

    assign sum_sat = sat_add(now_reg, add_b);

    assign fire          = live_reg[idx_reg] && (now_reg > rd_deadline);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign mpt_next      = cfg_we ? cfg_wdata : mpt_reg;

    always_comb
    begin
        state_next = state_reg;
        now_next   = now_reg;
        live_next  = live_reg;
        prod_next  = prod_reg;
        delay_next = delay_reg;
        once_next  = once_reg;
        sid_next   = sid_reg;
        idx_next   = idx_reg;
        rd_addr    = idx_reg;
        ram_we     = 1'b0;
        ram_wdata  = {rd_once, rd_period, sum_sat};
        emit       = 1'b0;
        emit_kind  = KIND_TICK_DONE;
        emit_slot  = '0;
        emit_last  = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    prod_next  = PROD_W'(s_axis_tdata[EXP_W-1:0] * mpt_reg);
                    delay_next = s_axis_tdata[EXP_W +: PERIOD_W];
                    once_next  = s_axis_tdata[EXP_W + PERIOD_W];
                    sid_next   = s_axis_tdata[EXP_W + PERIOD_W + 1 +: SLOT_FIELD_W];
                    idx_next   = '0;
                    case (s_axis_tuser)
                        REQ_TICK:   state_next = ST_TICK_ADD;
                        REQ_ADD:    state_next = ST_ADD_FIND;
                        REQ_CANCEL: state_next = ST_CANCEL;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TICK_ADD:
            begin
                now_next   = sum_sat;
                rd_addr    = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // memory data belongs to idx_reg; hold the read while a firing slot waits for a busy output
                if (!fire || out_free)
                begin
                    if (fire)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_FIRED;
                        emit_slot = SLOT_FIELD_W'(idx_reg);
                        emit_last = 1'b0;
                        if (rd_once)
                        begin
                            live_next[idx_reg] = 1'b0;
                        end
                        else
                        begin
                            ram_we = 1'b1;
                        end
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_TICK_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end
            ST_TICK_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_TICK_DONE;
                    state_next = ST_IDLE;
                end
            end
            ST_ADD_FIND:
            begin
                if (!live_reg[idx_reg])
                begin
                    state_next = ST_ADD_WR;
                end
                else if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_FULL;
                    state_next = ST_IDLE;
                end
            end
            ST_ADD_WR:
            begin
                if (out_free)
                begin
                    ram_we             = 1'b1;
                    ram_wdata          = {once_reg, delay_reg, sum_sat};
                    live_next[idx_reg] = 1'b1;
                    emit               = 1'b1;
                    emit_kind          = KIND_ADDED;
                    emit_slot          = SLOT_FIELD_W'(idx_reg);
                    state_next         = ST_IDLE;
                end
            end
            ST_CANCEL:
            begin
                if (out_free)
                begin
                    // out-of-range slot ids match no entry and leave the table alone
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (i < (1 << SLOT_FIELD_W) && SLOT_FIELD_W'(i) == sid_reg)
                        begin
                            live_next[i] = 1'b0;
                        end
                    end
                    emit       = 1'b1;
                    emit_kind  = KIND_CANCELLED;
                    emit_slot  = sid_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = emit ? 1'b1 : (out_valid_reg && !m_axis_tready);
    assign out_kind_next  = emit ? emit_kind : out_kind_reg;
    assign out_slot_next  = emit ? emit_slot : out_slot_reg;
    assign out_last_next  = emit ? emit_last : out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            mpt_reg       <= MPT_RESET;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            mpt_reg       <= mpt_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        delay_reg    <= delay_next;
        once_reg     <= once_next;
        sid_reg      <= sid_next;
        idx_reg      <= idx_next;
        out_kind_reg <= out_kind_next;
        out_slot_reg <= out_slot_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_slot_reg, out_kind_reg});
    assign m_axis_tlast  = out_last_reg;

    `ASSERT_ALWAYS(a_now_monotonic, now_reg >= $past(now_reg), "time went backwards")
    `ASSERT_IMPL(a_add_slot_free, state_reg == ST_ADD_WR, !live_reg[idx_reg],
                 "add targets a live slot")
    `ASSERT_IMPL(a_fired_not_last, out_valid_reg && out_kind_reg == KIND_FIRED,
                 !out_last_reg, "fired item marked last")

endmodule
`default_nettype wire

/* hdl/tmt_ram.sv */
`default_nettype none
module tmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire
